// ===== hw/rtl/rrcqs_pkg.sv =====
package rrcqs_pkg;

    // Default sizing of the scheduler
    localparam int MAX_CLIENTS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int CMD_W     = 1;
    localparam int ID_W      = 3;
    localparam int TAG_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int PENDOUT_W = 8;
    localparam int ACTIVE_W  = 4;

    // Width used for client count compares
    localparam int CMP_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_QUEUED     = 3'd0,
        STAT_BAD_ID     = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_DISPATCHED = 3'd3,
        STAT_EMPTY      = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PICK,
        ST_LOOKUP,
        ST_EXEC,
        ST_TAG,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/rrcqs_tag_ram.sv =====
module rrcqs_tag_ram #(
    parameter int DEPTH  = rrcqs_pkg::MAX_CLIENTS_DEF * rrcqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [rrcqs_pkg::TAG_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [rrcqs_pkg::TAG_W-1:0]   rd_data
);

    logic [rrcqs_pkg::TAG_W-1:0] mem [DEPTH];
    logic [rrcqs_pkg::TAG_W-1:0] rd_data_reg;

    // Write one tag slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rrcqs_meta_ram.sv =====
module rrcqs_meta_ram #(
    parameter int DEPTH  = rrcqs_pkg::MAX_CLIENTS_DEF,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    // Write client metadata
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark entries written since reset; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/rrcqs_picker.sv =====
module rrcqs_picker #(
    parameter int MAX_CLIENTS = rrcqs_pkg::MAX_CLIENTS_DEF,
    parameter int CID_W       = 3,
    parameter int NW          = 4
) (
    input  logic [MAX_CLIENTS-1:0] nonempty,
    input  logic [NW-1:0]          active_n,
    input  logic [CID_W-1:0]       start,
    output logic                   found,
    output logic [CID_W-1:0]       client
);

    logic [MAX_CLIENTS-1:0] lo_mask;
    logic [MAX_CLIENTS-1:0] hi_mask;
    logic [CID_W-1:0]       pick_lo;
    logic [CID_W-1:0]       pick_hi;

    // Mask occupancy by rotation membership and by position from the start
    always_comb
    begin
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            lo_mask[i] = nonempty[i]
                && (rrcqs_pkg::CMP_W'(i) < rrcqs_pkg::CMP_W'(active_n));
            hi_mask[i] = lo_mask[i]
                && (rrcqs_pkg::CMP_W'(i) >= rrcqs_pkg::CMP_W'(start));
        end
    end

    // Find lowest set client in each mask
    always_comb
    begin
        pick_lo = '0;
        pick_hi = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--)
        begin
            if (lo_mask[i])
            begin
                pick_lo = CID_W'(i);
            end
            if (hi_mask[i])
            begin
                pick_hi = CID_W'(i);
            end
        end
    end

    // Prefer clients at or after the start, then wrap
    assign found  = |lo_mask;
    assign client = (|hi_mask) ? pick_hi : pick_lo;

endmodule

// ===== hw/rtl/round_robin_client_queue_scheduler_top.sv =====
// Round-robin scheduler over per-client tag FIFOs. One item is in work at a
// time; in_ready is high only while the sequencer waits for an item, and a
// finished result sits in an output register so the next item can be taken
// while it waits. An enqueue reads the client metadata memory (a registered
// read) and then writes the tag and the metadata back; a client id outside
// the rotation goes straight to the result. A dispatch first subtracts the
// active count from the cursor until it is in range (never, unless the
// rotation was shrunk), then picks a client, reads its metadata, and then
// reads the tag memory while writing the metadata back; a dispatch that finds
// nothing goes straight to the result. A wait on out_ready holds the result
// back before the next item is taken. Metadata reads as zero until first
// written and occupancy bits clear at reset; no clearing pass is needed.
module round_robin_client_queue_scheduler_top #(
    parameter int MAX_CLIENTS = rrcqs_pkg::MAX_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = rrcqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [rrcqs_pkg::ACTIVE_W-1:0]    cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rrcqs_pkg::CMD_W-1:0]       command,
    input  logic [rrcqs_pkg::ID_W-1:0]        target_client,
    input  logic [rrcqs_pkg::TAG_W-1:0]       request_tag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rrcqs_pkg::STATUS_W-1:0]    status,
    output logic [rrcqs_pkg::ID_W-1:0]        served_client,
    output logic [rrcqs_pkg::TAG_W-1:0]       served_tag,
    output logic [rrcqs_pkg::PENDOUT_W-1:0]   pending_total
);

    localparam int CID_W  = $clog2(MAX_CLIENTS > 1 ? MAX_CLIENTS : 2);
    localparam int NW     = $clog2(MAX_CLIENTS + 1);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int META_W = 2 * PTR_W + LEN_W;
    localparam int TDEPTH = MAX_CLIENTS * QUEUE_DEPTH;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int PEND_W = $clog2(TDEPTH + 1);
    localparam int CW     = rrcqs_pkg::CMP_W;

    rrcqs_pkg::state_t  state_reg, state_next;

    logic [rrcqs_pkg::ACTIVE_W-1:0] active_reg;
    logic [rrcqs_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [rrcqs_pkg::TAG_W-1:0]    tag_reg, tag_next;
    logic [CID_W-1:0]               start_reg, start_next;
    logic [CID_W-1:0]               client_reg, client_next;
    logic [CID_W-1:0]               cursor_reg, cursor_next;
    logic [PEND_W-1:0]              pending_reg, pending_next;
    logic [MAX_CLIENTS-1:0]         nonempty_reg, nonempty_next;
    rrcqs_pkg::status_t             res_status_reg, res_status_next;
    logic [CID_W-1:0]               res_client_reg, res_client_next;
    logic [rrcqs_pkg::TAG_W-1:0]    res_tag_reg, res_tag_next;

    logic                           out_valid_reg, out_valid_next;
    logic [rrcqs_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [rrcqs_pkg::ID_W-1:0]     out_client_reg, out_client_next;
    logic [rrcqs_pkg::TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [PEND_W-1:0]              out_pending_reg, out_pending_next;

    logic [NW-1:0]                  n_eff;
    logic [CW-1:0]                  active_ext;
    logic                           pick_found;
    logic [CID_W-1:0]               pick_client;

    logic                           meta_wr_en;
    logic [META_W-1:0]              meta_wr_data;
    logic                           meta_rd_en;
    logic [META_W-1:0]              meta_rd_data;
    logic [PTR_W-1:0]               meta_head;
    logic [PTR_W-1:0]               meta_tail;
    logic [LEN_W-1:0]               meta_len;
    logic [PTR_W-1:0]               head_adv;
    logic [PTR_W-1:0]               tail_adv;

    logic                           tag_wr_en;
    logic                           tag_rd_en;
    logic [TA_W-1:0]                tag_wr_addr;
    logic [TA_W-1:0]                tag_rd_addr;
    logic [rrcqs_pkg::TAG_W-1:0]    tag_rd_data;
    logic [CW-1:0]                  cursor_inc;

    // Clamp the register into the range 1..MAX_CLIENTS
    assign active_ext = CW'(active_reg);
    always_comb
    begin
        if (active_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (active_ext > CW'(MAX_CLIENTS))
        begin
            n_eff = NW'(MAX_CLIENTS);
        end
        else
        begin
            n_eff = NW'(active_ext);
        end
    end

    // Unpack metadata and advance pointers with wrap
    assign {meta_head, meta_tail, meta_len} = meta_rd_data;
    assign head_adv = (meta_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : meta_head + 1'b1;
    assign tail_adv = (meta_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : meta_tail + 1'b1;
    assign cursor_inc = CW'(client_reg) + 1'b1;

    assign tag_wr_addr = TA_W'(32'(client_reg) * 32'(QUEUE_DEPTH) + 32'(meta_tail));
    assign tag_rd_addr = TA_W'(32'(client_reg) * 32'(QUEUE_DEPTH) + 32'(meta_head));

    rrcqs_picker #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .CID_W       (CID_W),
        .NW          (NW)
    ) u_picker (
        .nonempty (nonempty_reg),
        .active_n (n_eff),
        .start    (start_reg),
        .found    (pick_found),
        .client   (pick_client)
    );

    rrcqs_meta_ram #(
        .DEPTH  (MAX_CLIENTS),
        .ADDR_W (CID_W),
        .DATA_W (META_W)
    ) u_meta_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (meta_wr_en),
        .wr_addr (client_reg),
        .wr_data (meta_wr_data),
        .rd_en   (meta_rd_en),
        .rd_addr (client_reg),
        .rd_data (meta_rd_data)
    );

    rrcqs_tag_ram #(
        .DEPTH  (TDEPTH),
        .ADDR_W (TA_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= rrcqs_pkg::ACTIVE_W'(8);
        end
        else if (cfg_write_en)
        begin
            active_reg <= cfg_write_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrcqs_pkg::ST_IDLE;
            cursor_reg    <= '0;
            pending_reg   <= '0;
            nonempty_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            pending_reg   <= pending_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        tag_reg         <= tag_next;
        start_reg       <= start_next;
        client_reg      <= client_next;
        res_status_reg  <= res_status_next;
        res_client_reg  <= res_client_next;
        res_tag_reg     <= res_tag_next;
        out_status_reg  <= out_status_next;
        out_client_reg  <= out_client_next;
        out_tag_reg     <= out_tag_next;
        out_pending_reg <= out_pending_next;
    end

    // Sequence one item through lookup, update and result
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        tag_next         = tag_reg;
        start_next       = start_reg;
        client_next      = client_reg;
        cursor_next      = cursor_reg;
        pending_next     = pending_reg;
        nonempty_next    = nonempty_reg;
        res_status_next  = res_status_reg;
        res_client_next  = res_client_reg;
        res_tag_next     = res_tag_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_client_next  = out_client_reg;
        out_tag_next     = out_tag_reg;
        out_pending_next = out_pending_reg;
        in_ready         = 1'b0;
        meta_rd_en       = 1'b0;
        meta_wr_en       = 1'b0;
        meta_wr_data     = meta_rd_data;
        tag_wr_en        = 1'b0;
        tag_rd_en        = 1'b0;

        // Drop a result the consumer took
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rrcqs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next        = command;
                    tag_next        = request_tag;
                    client_next     = CID_W'(target_client);
                    start_next      = cursor_reg;
                    res_client_next = '0;
                    res_tag_next    = '0;
                    if (command == rrcqs_pkg::CMD_DISPATCH)
                    begin
                        state_next = rrcqs_pkg::ST_MOD;
                    end
                    else if (CW'(target_client) >= CW'(n_eff))
                    begin
                        res_status_next = rrcqs_pkg::STAT_BAD_ID;
                        state_next      = rrcqs_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rrcqs_pkg::ST_LOOKUP;
                    end
                end
            end

            rrcqs_pkg::ST_MOD:
            begin
                // Reduce the start point below the active count
                if (CW'(start_reg) >= CW'(n_eff))
                begin
                    start_next = CID_W'(CW'(start_reg) - CW'(n_eff));
                end
                else
                begin
                    state_next = rrcqs_pkg::ST_PICK;
                end
            end

            rrcqs_pkg::ST_PICK:
            begin
                if (pick_found)
                begin
                    client_next = pick_client;
                    state_next  = rrcqs_pkg::ST_LOOKUP;
                end
                else
                begin
                    res_status_next = rrcqs_pkg::STAT_EMPTY;
                    state_next      = rrcqs_pkg::ST_DONE;
                end
            end

            rrcqs_pkg::ST_LOOKUP:
            begin
                meta_rd_en = 1'b1;
                state_next = rrcqs_pkg::ST_EXEC;
            end

            rrcqs_pkg::ST_EXEC:
            begin
                if (cmd_reg == rrcqs_pkg::CMD_DISPATCH)
                begin
                    // Pop the head and pass the turn on
                    tag_rd_en    = 1'b1;
                    meta_wr_en   = 1'b1;
                    meta_wr_data = {head_adv, meta_tail, meta_len - 1'b1};
                    pending_next = pending_reg - 1'b1;
                    if (meta_len == LEN_W'(1))
                    begin
                        nonempty_next[client_reg] = 1'b0;
                    end
                    cursor_next     = (cursor_inc == CW'(n_eff)) ? '0 : CID_W'(cursor_inc);
                    res_status_next = rrcqs_pkg::STAT_DISPATCHED;
                    res_client_next = client_reg;
                    state_next      = rrcqs_pkg::ST_TAG;
                end
                else if (meta_len == LEN_W'(QUEUE_DEPTH))
                begin
                    res_status_next = rrcqs_pkg::STAT_FULL;
                    state_next      = rrcqs_pkg::ST_DONE;
                end
                else
                begin
                    // Append at the tail
                    tag_wr_en                 = 1'b1;
                    meta_wr_en                = 1'b1;
                    meta_wr_data              = {meta_head, tail_adv, meta_len + 1'b1};
                    pending_next              = pending_reg + 1'b1;
                    nonempty_next[client_reg] = 1'b1;
                    res_status_next           = rrcqs_pkg::STAT_QUEUED;
                    state_next                = rrcqs_pkg::ST_DONE;
                end
            end

            rrcqs_pkg::ST_TAG:
            begin
                res_tag_next = tag_rd_data;
                state_next   = rrcqs_pkg::ST_DONE;
            end

            rrcqs_pkg::ST_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_client_next  = rrcqs_pkg::ID_W'(res_client_reg);
                    out_tag_next     = res_tag_reg;
                    out_pending_next = pending_reg;
                    state_next       = rrcqs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rrcqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign served_client = out_client_reg;
    assign served_tag    = out_tag_reg;
    assign pending_total = rrcqs_pkg::PENDOUT_W'(out_pending_reg);

    // A dispatch only reaches update on a client the picker saw as occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrcqs_pkg::ST_EXEC && cmd_reg == rrcqs_pkg::CMD_DISPATCH)
        |-> (meta_len != '0))
        else $error("dispatch from an empty client queue");

    // Occupancy bit agrees with stored length at update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rrcqs_pkg::ST_EXEC) |-> (nonempty_reg[client_reg] == (meta_len != '0)))
        else $error("occupancy bit disagrees with queue length");

    // Pending count moves only in the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rrcqs_pkg::ST_EXEC) |=> $stable(pending_reg))
        else $error("pending count changed outside update");

    // Non-dispatch results carry zero client and tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != rrcqs_pkg::STAT_DISPATCHED)
        |-> (served_client == '0 && served_tag == '0))
        else $error("served fields set on a non-dispatch result");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int NCLIENTS     = rrcqs_pkg::MAX_CLIENTS_DEF;
    localparam int QDEPTH       = rrcqs_pkg::QUEUE_DEPTH_DEF;
    localparam int ITEM_TARGET  = 1150;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 120;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        rrcqs_pkg::status_t                 st;
        logic [rrcqs_pkg::ID_W-1:0]         client;
        logic [rrcqs_pkg::TAG_W-1:0]        tag;
        logic [rrcqs_pkg::PENDOUT_W-1:0]    pending;
    } sched_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [rrcqs_pkg::CMD_W-1:0]        cmd;
        logic [rrcqs_pkg::ID_W-1:0]         cid;
        logic [rrcqs_pkg::TAG_W-1:0]        tag;
        logic [rrcqs_pkg::ACTIVE_W-1:0]     cfg_val;
        bit                                 typed;
        rrcqs_pkg::status_t                 typed_st;
        logic [rrcqs_pkg::PENDOUT_W-1:0]    typed_pd;
    } plan_row_t;

    typedef enum int {MIX_FILL, MIX_ENQ, MIX_DRAIN, MIX_EVEN} traffic_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_write_en;
    logic [rrcqs_pkg::ACTIVE_W-1:0]         cfg_write_data;
    logic                                   in_valid;
    logic                                   in_ready;
    logic [rrcqs_pkg::CMD_W-1:0]            command;
    logic [rrcqs_pkg::ID_W-1:0]             target_client;
    logic [rrcqs_pkg::TAG_W-1:0]            request_tag;
    logic                                   out_valid;
    logic                                   out_ready;
    logic [rrcqs_pkg::STATUS_W-1:0]         status;
    logic [rrcqs_pkg::ID_W-1:0]             served_client;
    logic [rrcqs_pkg::TAG_W-1:0]            served_tag;
    logic [rrcqs_pkg::PENDOUT_W-1:0]        pending_total;

    // Scheduler shadow state
    logic [rrcqs_pkg::TAG_W-1:0]            fifo_tags [NCLIENTS][QDEPTH];
    int                                     rd_slot [NCLIENTS];
    int                                     wr_slot [NCLIENTS];
    int                                     fifo_fill [NCLIENTS];
    int                                     next_turn;
    int                                     waiting_total;
    logic [rrcqs_pkg::ACTIVE_W-1:0]         rotation_reg;

    sched_result_t                          expected_results [$];
    plan_row_t                              plan [$];

    int                                     err_count = 0;
    int                                     items_sent;
    int                                     results_seen = 0;
    int                                     cfg_writes;
    int                                     long_holds = 0;
    int                                     quiet_cycles = 0;
    int                                     status_hits [5] = '{default: 0};
    bit                                     no_idle;

    round_robin_client_queue_scheduler_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .target_client  (target_client),
        .request_tag    (request_tag),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .served_client  (served_client),
        .served_tag     (served_tag),
        .pending_total  (pending_total)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Clamp the register value to the rotation size actually used
    function automatic int rotation_size();
        int n;
        n = int'(rotation_reg);
        if (n < 1) n = 1;
        if (n > NCLIENTS) n = NCLIENTS;
        return n;
    endfunction

    // Apply one item to the shadow state and return its result
    task automatic schedule_item(input logic [rrcqs_pkg::CMD_W-1:0] cmd,
                                 input logic [rrcqs_pkg::ID_W-1:0] cid,
                                 input logic [rrcqs_pkg::TAG_W-1:0] tag,
                                 output sched_result_t res);
        int n;
        int first;
        int c;
        bit found;
        n = rotation_size();
        found = 1'b0;
        res.st = rrcqs_pkg::STAT_EMPTY;
        res.client = '0;
        res.tag = '0;
        if (cmd == rrcqs_pkg::CMD_ENQUEUE)
        begin
            if (int'(cid) >= n)
            begin
                res.st = rrcqs_pkg::STAT_BAD_ID;
            end
            else if (fifo_fill[cid] >= QDEPTH)
            begin
                res.st = rrcqs_pkg::STAT_FULL;
            end
            else
            begin
                fifo_tags[cid][wr_slot[cid]] = tag;
                wr_slot[cid] = (wr_slot[cid] + 1) % QDEPTH;
                fifo_fill[cid]++;
                waiting_total++;
                res.st = rrcqs_pkg::STAT_QUEUED;
            end
        end
        else if (waiting_total != 0)
        begin
            // Sweep the active clients from the cursor, wrapped into range
            first = next_turn % n;
            for (int s = 0; s < n && !found; s++)
            begin
                c = (first + s) % n;
                if (fifo_fill[c] != 0)
                begin
                    found = 1'b1;
                    res.st = rrcqs_pkg::STAT_DISPATCHED;
                    res.client = c[rrcqs_pkg::ID_W-1:0];
                    res.tag = fifo_tags[c][rd_slot[c]];
                    rd_slot[c] = (rd_slot[c] + 1) % QDEPTH;
                    fifo_fill[c]--;
                    waiting_total--;
                    next_turn = (c + 1) % n;
                end
            end
        end
        res.pending = waiting_total[rrcqs_pkg::PENDOUT_W-1:0];
    endtask

    task automatic add_item(input logic [rrcqs_pkg::CMD_W-1:0] cmd,
                            input logic [rrcqs_pkg::ID_W-1:0] cid,
                            input logic [rrcqs_pkg::TAG_W-1:0] tag, input bit typed,
                            input rrcqs_pkg::status_t typed_st,
                            input logic [rrcqs_pkg::PENDOUT_W-1:0] typed_pd);
        plan_row_t row;
        row.kind = ROW_ITEM;
        row.cmd = cmd;
        row.cid = cid;
        row.tag = tag;
        row.cfg_val = '0;
        row.typed = typed;
        row.typed_st = typed_st;
        row.typed_pd = typed_pd;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic [rrcqs_pkg::ACTIVE_W-1:0] val);
        plan_row_t row;
        row.kind = ROW_CFG;
        row.cmd = rrcqs_pkg::CMD_ENQUEUE;
        row.cid = '0;
        row.tag = '0;
        row.cfg_val = val;
        row.typed = 1'b0;
        row.typed_st = rrcqs_pkg::STAT_QUEUED;
        row.typed_pd = '0;
        plan.push_back(row);
    endtask

    task automatic flag_mismatch(input string what, input logic [rrcqs_pkg::TAG_W-1:0] got,
                                 input logic [rrcqs_pkg::TAG_W-1:0] want);
        $display("tb: result %0d %s got %0h want %0h", results_seen, what, got, want);
        err_count++;
    endtask

    // Offer one item and hold it until accepted, then record its result
    task automatic send_item(input logic [rrcqs_pkg::CMD_W-1:0] cmd,
                             input logic [rrcqs_pkg::ID_W-1:0] cid,
                             input logic [rrcqs_pkg::TAG_W-1:0] tag, input bit typed,
                             input rrcqs_pkg::status_t typed_st,
                             input logic [rrcqs_pkg::PENDOUT_W-1:0] typed_pd);
        sched_result_t res;
        @(negedge clk);
        in_valid = 1'b1;
        command = cmd;
        target_client = cid;
        request_tag = tag;
        do @(posedge clk); while (!in_ready);
        schedule_item(cmd, cid, tag, res);
        if (typed)
        begin
            res.st = typed_st;
            res.client = '0;
            res.tag = '0;
            res.pending = typed_pd;
        end
        expected_results.push_back(res);
        items_sent++;
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_rotation(input logic [rrcqs_pkg::ACTIVE_W-1:0] val);
        wait_drain();
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_write_data = val;
        @(posedge clk);
        rotation_reg = val;
        @(negedge clk);
        cfg_write_en = 1'b0;
        cfg_writes++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [rrcqs_pkg::ACTIVE_W-1:0] pick_rotation();
        case ($urandom_range(0, 5))
            0: return 4'd0;
            1: return 4'd1;
            2: return 4'd8;
            3: return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                flag_mismatch("with nothing expected, status",
                              rrcqs_pkg::TAG_W'(status), '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st)
                    flag_mismatch("status", rrcqs_pkg::TAG_W'(status),
                                  rrcqs_pkg::TAG_W'(want.st));
                if (served_client !== want.client)
                    flag_mismatch("served_client", rrcqs_pkg::TAG_W'(served_client),
                                  rrcqs_pkg::TAG_W'(want.client));
                if (served_tag !== want.tag)
                    flag_mismatch("served_tag", served_tag, want.tag);
                if (pending_total !== want.pending)
                    flag_mismatch("pending_total", rrcqs_pkg::TAG_W'(pending_total),
                                  rrcqs_pkg::TAG_W'(want.pending));
                status_hits[want.st]++;
            end
            results_seen++;
        end
    end

    // End the run when no item moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: stalled for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, calm stretches, and long holds while items keep coming
    initial
    begin
        int hold_left;
        int calm_left;
        int r;
        hold_left = 0;
        calm_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_holds < 2 && results_seen >= 150 + 550 * long_holds && in_valid)
            begin
                hold_left = LONG_HOLD;
                calm_left = 0;
                long_holds++;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (calm_left > 0)
            begin
                out_ready = 1'b1;
                calm_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_ready = 1'b1;
                end
                else if (r < 88)
                begin
                    out_ready = 1'b0;
                    hold_left = $urandom_range(0, 2);
                end
                else if (r < 93)
                begin
                    out_ready = 1'b0;
                    hold_left = $urandom_range(8, 25);
                end
                else
                begin
                    out_ready = 1'b1;
                    calm_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Sender: reset, directed table, then random traffic phases
    initial
    begin
        traffic_t mode;
        int n;
        int focus;
        int phase_len;
        int enq_pct;
        logic [rrcqs_pkg::CMD_W-1:0] cmd;
        logic [rrcqs_pkg::ID_W-1:0] cid;

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        command = rrcqs_pkg::CMD_ENQUEUE;
        target_client = '0;
        request_tag = '0;
        items_sent = 0;
        cfg_writes = 0;
        no_idle = 1'b0;
        for (int c = 0; c < NCLIENTS; c++)
        begin
            rd_slot[c] = 0;
            wr_slot[c] = 0;
            fifo_fill[c] = 0;
        end
        next_turn = 0;
        waiting_total = 0;
        rotation_reg = 4'd8;

        // Empty after reset, extreme ids and tags, plain rotation
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd7, 32'hFFFF_FFFF, 1'b1,
                 rrcqs_pkg::STAT_EMPTY, 8'd0);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd7, 32'hFFFF_FFFF, 1'b1,
                 rrcqs_pkg::STAT_QUEUED, 8'd1);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd0, 32'h0000_0000, 1'b1,
                 rrcqs_pkg::STAT_QUEUED, 8'd2);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd0, 32'hA5A5_A5A5, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0000_0000, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd5, 32'h1234_5678, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd2, 32'hFFFF_FFFF, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0000_0000, 1'b1,
                 rrcqs_pkg::STAT_EMPTY, 8'd0);
        // Walk the cursor up to the last client
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd3, 32'h3333_0003, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd6, 32'h6666_0006, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd1, 32'h0, 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd1, 32'h0, 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd1, 32'h1111_0001, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd2, 32'h2222_0002, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd5, 32'h5555_0005, 1'b0,
                 rrcqs_pkg::STAT_QUEUED, 8'd0);
        // Shrink the rotation: cursor out of range, client 5 left stranded
        add_cfg(4'd3);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd5, 32'hDEAD_0005, 1'b1,
                 rrcqs_pkg::STAT_BAD_ID, 8'd3);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd7, 32'hDEAD_0007, 1'b1,
                 rrcqs_pkg::STAT_BAD_ID, 8'd3);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0, 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0, 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0, 1'b1, rrcqs_pkg::STAT_EMPTY, 8'd1);
        // Zero acts as one client
        add_cfg(4'd0);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd1, 32'hBEEF_0001, 1'b1,
                 rrcqs_pkg::STAT_BAD_ID, 8'd1);
        add_item(rrcqs_pkg::CMD_ENQUEUE, 3'd0, 32'h1234_5678, 1'b1,
                 rrcqs_pkg::STAT_QUEUED, 8'd2);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0, 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
        // Out-of-range value acts as all clients, stranded tag comes back
        add_cfg(4'd15);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0, 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
        add_item(rrcqs_pkg::CMD_DISPATCH, 3'd0, 32'h0, 1'b1, rrcqs_pkg::STAT_EMPTY, 8'd0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                write_rotation(plan[i].cfg_val);
            end
            else
            begin
                send_item(plan[i].cmd, plan[i].cid, plan[i].tag, plan[i].typed,
                          plan[i].typed_st, plan[i].typed_pd);
                idle_sender(pick_gap());
            end
        end

        // Random phases, each under its own rotation size and traffic mix
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 6) write_rotation(pick_rotation());
            n = rotation_size();
            mode = traffic_t'($urandom_range(0, 3));
            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(25, 50);
            focus = $urandom_range(0, n - 1);
            case (mode)
                MIX_ENQ:   enq_pct = 75;
                MIX_DRAIN: enq_pct = 25;
                default:   enq_pct = 50;
            endcase
            for (int k = 0; k < phase_len; k++)
            begin
                if (mode == MIX_FILL && k < QDEPTH + 3)
                begin
                    // Fill one client past its depth
                    cmd = rrcqs_pkg::CMD_ENQUEUE;
                    cid = focus[rrcqs_pkg::ID_W-1:0];
                end
                else
                begin
                    cmd = ($urandom_range(0, 99) < enq_pct) ? rrcqs_pkg::CMD_ENQUEUE
                                                           : rrcqs_pkg::CMD_DISPATCH;
                    if ($urandom_range(0, 99) < 85)
                        cid = rrcqs_pkg::ID_W'($urandom_range(0, n - 1));
                    else
                        cid = rrcqs_pkg::ID_W'($urandom_range(0, NCLIENTS - 1));
                end
                send_item(cmd, cid, $urandom(), 1'b0, rrcqs_pkg::STAT_QUEUED, 8'd0);
                idle_sender(pick_gap());
            end
        end

        wait_drain();
        $display("tb: %0d items, %0d results checked, %0d rotation writes, %0d long holds",
                 items_sent, results_seen, cfg_writes, long_holds);
        $display("tb: queued %0d, bad id %0d, full %0d, dispatched %0d, empty %0d",
                 status_hits[rrcqs_pkg::STAT_QUEUED], status_hits[rrcqs_pkg::STAT_BAD_ID],
                 status_hits[rrcqs_pkg::STAT_FULL], status_hits[rrcqs_pkg::STAT_DISPATCHED],
                 status_hits[rrcqs_pkg::STAT_EMPTY]);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rrcqs_pkg.sv
hw/rtl/rrcqs_tag_ram.sv
hw/rtl/rrcqs_meta_ram.sv
hw/rtl/rrcqs_picker.sv
hw/rtl/round_robin_client_queue_scheduler_top.sv
tb/sv/testbench.sv
